// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALW(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif
`endif

// ----- rtl/fct_pkg.sv -----
// Package for the chain table engine: widths, codes and interface structs.
// No dependencies.
package fct_pkg;

    localparam int IDX_W   = 12;
    localparam int CNT_W   = IDX_W + 1;
    localparam int DATA_W  = 32;
    localparam int STEPS_W = 12;
    localparam int LAST_W  = 12;
    localparam int DS_W    = 16;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0]  IDX_MAX  = {IDX_W{1'b1}};
    localparam logic [DATA_W-1:0] END_MARK = 32'h0FFF_FFFF;
    localparam logic [LAST_W-1:0] LAST_RST = 12'hFFF;
    localparam logic [DS_W-1:0]   DS_RST   = 16'h0000;

    localparam logic [ACT_W-1:0] ACT_GET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GROW  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FREE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WALK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_WALKX = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DSTART = 1'd1;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_INC = 2'd0;
    localparam t_alu_op ALU_DEC = 2'd1;
    localparam t_alu_op ALU_ADD = 2'd2;

    typedef struct packed {
        t_alu_op            op;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [DATA_W-1:0]  wdata;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic [DATA_W-1:0]  result;
        logic               ok;
    } t_res;

endpackage

// ----- rtl/fat_chain_table_engine.sv -----
// Top level of the chain table engine: config registers, result register,
// sequencer, shared adder and table. Depends on fct_pkg, fct_ctrl,
// fct_alu, fct_table and assert_macros.svh.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+----------------------------------
//  in       | i_in_valid / o_in_ready    | action cluster value prev steps
//  out      | o_out_valid / i_out_ready  | result ok
//  cfg      | i_cfg_we (write only)      | i_cfg_index, i_cfg_data
//
// After reset the table is swept to zero, one entry per cycle, with o_in_ready
// low until every entry is cleared. Get and put pass through S_GET or S_PUT
// and then S_DONE, which hands the result to the output register.
// Scans step S_SC_RD/S_SC_CHK per entry, walks S_TR_CHK/S_TR_NXT and frees
// S_FR_CHK/S_FR_CLR per link; all go through the single table read port.
// A stalled output holds the result in its register; the sequencer waits in
// its final state and the input stays not ready until the word is taken.
`include "assert_macros.svh"

module fat_chain_table_engine
    import fct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [ACT_W-1:0]        i_action,
    input  logic [IDX_W-1:0]        i_cluster,
    input  logic [DATA_W-1:0]       i_value,
    input  logic [IDX_W-1:0]        i_prev_cluster,
    input  logic [STEPS_W-1:0]      i_steps,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [DATA_W-1:0]       o_result,
    output logic                    o_ok,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [LAST_W-1:0]  r_last_cluster;
    logic [DS_W-1:0]    r_data_start;
    logic               r_ovalid;
    logic [DATA_W-1:0]  r_result;
    logic               r_ok;

    t_mem_req           w_mem;
    t_alu_req           w_alu;
    t_res               w_res;
    logic [DATA_W-1:0]  w_rdata;
    logic [DATA_W-1:0]  w_alu_y;
    logic               w_res_ready;

    assign w_res_ready = !r_ovalid || i_out_ready;

    fct_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_cluster      (i_cluster),
        .i_value        (i_value),
        .i_prev_cluster (i_prev_cluster),
        .i_steps        (i_steps),
        .i_last_cluster (r_last_cluster),
        .i_data_start   (r_data_start),
        .o_mem          (w_mem),
        .i_rdata        (w_rdata),
        .o_alu          (w_alu),
        .i_alu_y        (w_alu_y),
        .o_res          (w_res),
        .i_res_ready    (w_res_ready)
    );

    fct_alu u_alu (
        .i_req (w_alu),
        .o_y   (w_alu_y)
    );

    fct_table u_table (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cluster <= LAST_RST;
            r_data_start   <= DS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LAST:   r_last_cluster <= i_cfg_data[LAST_W-1:0];
                CFG_DSTART: r_data_start   <= i_cfg_data[DS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res.valid && w_res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_res_ready) begin
            r_result <= w_res.result;
            r_ok     <= w_res.ok;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_result;
    assign o_ok        = r_ok;

    `ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `ASSERT_RST(a_fail_zero, i_clk, i_rst_n, (o_out_valid && !o_ok) |-> (o_result == '0))
    `ASSERT_RST(a_res_loaded, i_clk, i_rst_n, (w_res.valid && w_res_ready) |=> o_out_valid)
    `ASSERT_ALW(a_cfg_reset, i_clk, !i_rst_n |=> (r_last_cluster == LAST_RST))

endmodule

// ----- rtl/fct_alu.sv -----
// Shared adder: increment, decrement or add, used by the sequencer.
// Depends on fct_pkg.
module fct_alu
    import fct_pkg::*;
(
    input  t_alu_req            i_req,
    output logic [DATA_W-1:0]   o_y
);

    logic [DATA_W-1:0] w_b;

    always_comb begin
        case (i_req.op)
            ALU_INC: w_b = {{(DATA_W-1){1'b0}}, 1'b1};
            ALU_DEC: w_b = {DATA_W{1'b1}};
            ALU_ADD: w_b = i_req.b;
            default: w_b = '0;
        endcase
    end

    assign o_y = i_req.a + w_b;

endmodule

// ----- rtl/fct_table.sv -----
// Link table storage: one write port, one read port, registered read data.
// Depends on fct_pkg.
module fct_table
    import fct_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_req            i_req,
    output logic [DATA_W-1:0]   o_rdata
);

    logic [DATA_W-1:0] r_mem [2**IDX_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fct_ctrl.sv -----
// Sequencer: clearing pass, scans, chain walks and table updates.
// Depends on fct_pkg; drives fct_table and fct_alu through structs.
module fct_ctrl
    import fct_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [IDX_W-1:0]    i_cluster,
    input  logic [DATA_W-1:0]   i_value,
    input  logic [IDX_W-1:0]    i_prev_cluster,
    input  logic [STEPS_W-1:0]  i_steps,
    input  logic [LAST_W-1:0]   i_last_cluster,
    input  logic [DS_W-1:0]     i_data_start,
    output t_mem_req            o_mem,
    input  logic [DATA_W-1:0]   i_rdata,
    output t_alu_req            o_alu,
    input  logic [DATA_W-1:0]   i_alu_y,
    output t_res                o_res,
    input  logic                i_res_ready
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_GET    = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_SC_RD  = 4'd4;
    localparam logic [3:0] S_SC_CHK = 4'd5;
    localparam logic [3:0] S_SC_LNK = 4'd6;
    localparam logic [3:0] S_SC_END = 4'd7;
    localparam logic [3:0] S_TR_CHK = 4'd8;
    localparam logic [3:0] S_TR_NXT = 4'd9;
    localparam logic [3:0] S_TR_ADD = 4'd10;
    localparam logic [3:0] S_FR_CHK = 4'd11;
    localparam logic [3:0] S_FR_CLR = 4'd12;
    localparam logic [3:0] S_PV_RD  = 4'd13;
    localparam logic [3:0] S_PV_CHK = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

    logic [3:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_idx,   n_idx;
    logic [ACT_W-1:0]   r_act,   n_act;
    logic [IDX_W-1:0]   r_clst,  n_clst;
    logic [DATA_W-1:0]  r_val,   n_val;
    logic [IDX_W-1:0]   r_prev,  n_prev;
    logic [IDX_W-1:0]   r_tail,  n_tail;
    logic [STEPS_W-1:0] r_steps, n_steps;
    logic [DATA_W-1:0]  r_cur,   n_cur;
    logic [DATA_W-1:0]  r_res,   n_res;
    logic               r_ok,    n_ok;
    logic               w_cur_out;

    assign w_cur_out = (r_cur[DATA_W-1:IDX_W] != '0);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_act   = r_act;
        n_clst  = r_clst;
        n_val   = r_val;
        n_prev  = r_prev;
        n_tail  = r_tail;
        n_steps = r_steps;
        n_cur   = r_cur;
        n_res   = r_res;
        n_ok    = r_ok;
        o_in_ready = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_cur[IDX_W-1:0];
        o_mem.wdata = '0;
        o_mem.raddr = i_cluster;
        o_alu.op = ALU_INC;
        o_alu.a  = {{(DATA_W-CNT_W){1'b0}}, r_idx};
        o_alu.b  = '0;
        o_res.valid  = 1'b0;
        o_res.result = r_res;
        o_res.ok     = r_ok;
        case (r_state)
            S_CLR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[IDX_W-1:0];
                n_idx = i_alu_y[CNT_W-1:0];
                if (r_idx[IDX_W-1:0] == IDX_MAX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_clst  = i_cluster;
                    n_val   = i_value;
                    n_prev  = i_prev_cluster;
                    n_tail  = i_cluster;
                    n_steps = i_steps;
                    n_cur   = {{(DATA_W-IDX_W){1'b0}}, i_cluster};
                    n_res   = '0;
                    n_ok    = 1'b1;
                    case (i_action)
                        ACT_GET:  n_state = S_GET;
                        ACT_PUT:  n_state = S_PUT;
                        ACT_GROW: begin
                            n_idx   = CNT_ONE;
                            n_state = S_SC_RD;
                        end
                        ACT_FREE: begin
                            n_idx   = '0;
                            n_state = S_FR_CHK;
                        end
                        ACT_WALK, ACT_WALKX: n_state = S_TR_CHK;
                        default: begin
                            n_ok    = 1'b0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_res   = i_rdata;
                n_state = S_DONE;
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clst;
                o_mem.wdata = r_val;
                n_state = S_DONE;
            end
            S_SC_RD: begin
                o_mem.raddr = r_idx[IDX_W-1:0];
                if (r_idx > {1'b0, i_last_cluster}) begin
                    n_res   = '0;
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                o_mem.raddr = r_idx[IDX_W-1:0];
                if (i_rdata == '0) begin
                    n_state = (r_tail != '0) ? S_SC_LNK : S_SC_END;
                end else begin
                    n_idx   = i_alu_y[CNT_W-1:0];
                    n_state = S_SC_RD;
                end
            end
            S_SC_LNK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_tail;
                o_mem.wdata = {{(DATA_W-IDX_W){1'b0}}, r_idx[IDX_W-1:0]};
                n_state = S_SC_END;
            end
            S_SC_END: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[IDX_W-1:0];
                o_mem.wdata = END_MARK;
                if (r_act == ACT_WALKX) begin
                    o_alu.op = ALU_DEC;
                    o_alu.a  = {{(DATA_W-STEPS_W){1'b0}}, r_steps};
                    n_steps  = i_alu_y[STEPS_W-1:0];
                    n_cur    = {{(DATA_W-IDX_W){1'b0}}, r_idx[IDX_W-1:0]};
                    n_state  = S_TR_CHK;
                end else begin
                    n_res   = {{(DATA_W-IDX_W){1'b0}}, r_idx[IDX_W-1:0]};
                    n_state = S_DONE;
                end
            end
            S_TR_CHK: begin
                o_mem.raddr = r_cur[IDX_W-1:0];
                if (r_steps == '0) begin
                    n_state = S_TR_ADD;
                end else if (w_cur_out) begin
                    n_res   = '0;
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TR_NXT;
                end
            end
            S_TR_NXT: begin
                if (i_rdata == '0) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else if (i_rdata == END_MARK) begin
                    if (r_act == ACT_WALKX) begin
                        n_tail  = r_cur[IDX_W-1:0];
                        n_idx   = CNT_ONE;
                        n_state = S_SC_RD;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end
                end else begin
                    o_alu.op = ALU_DEC;
                    o_alu.a  = {{(DATA_W-STEPS_W){1'b0}}, r_steps};
                    n_steps  = i_alu_y[STEPS_W-1:0];
                    n_cur    = i_rdata;
                    n_state  = S_TR_CHK;
                end
            end
            S_TR_ADD: begin
                o_alu.op = ALU_ADD;
                o_alu.a  = r_cur;
                o_alu.b  = {{(DATA_W-DS_W){1'b0}}, i_data_start};
                n_res    = i_alu_y;
                n_state  = S_DONE;
            end
            S_FR_CHK: begin
                o_mem.raddr = r_cur[IDX_W-1:0];
                if (r_idx[CNT_W-1] || r_cur == END_MARK || r_cur == '0 || w_cur_out) begin
                    n_state = S_PV_RD;
                end else begin
                    n_state = S_FR_CLR;
                end
            end
            S_FR_CLR: begin
                o_mem.raddr = r_cur[IDX_W-1:0];
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cur[IDX_W-1:0];
                o_mem.wdata = '0;
                n_cur   = i_rdata;
                n_idx   = i_alu_y[CNT_W-1:0];
                n_state = S_FR_CHK;
            end
            S_PV_RD: begin
                o_mem.raddr = r_prev;
                n_state = (r_prev == '0) ? S_DONE : S_PV_CHK;
            end
            S_PV_CHK: begin
                if (i_rdata == {{(DATA_W-IDX_W){1'b0}}, r_clst}) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_prev;
                    o_mem.wdata = END_MARK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_clst  <= n_clst;
        r_val   <= n_val;
        r_prev  <= n_prev;
        r_tail  <= n_tail;
        r_steps <= n_steps;
        r_cur   <= n_cur;
        r_res   <= n_res;
        r_ok    <= n_ok;
    end

endmodule

// ----- bench/fat_chain_table_engine_test.sv -----
// Self-checking bench for fat_chain_table_engine: directed and random requests
// checked word by word against a behavioral mirror of the link table.
// Depends on fct_pkg and the engine RTL.
module fat_chain_table_engine_test;
    import fct_pkg::*;

    localparam int TBL_DEPTH   = 1 << IDX_W;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int MAX_HEADS   = 24;
    localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] result;
        logic              ok;
    } t_fat_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [ACT_W-1:0]      i_action;
    logic [IDX_W-1:0]      i_cluster;
    logic [DATA_W-1:0]     i_value;
    logic [IDX_W-1:0]      i_prev_cluster;
    logic [STEPS_W-1:0]    i_steps;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DATA_W-1:0]     o_result;
    logic                  o_ok;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [DATA_W-1:0] fat_mirror [TBL_DEPTH];
    logic [LAST_W-1:0] last_lim;
    logic [DS_W-1:0]   sect_base;
    t_fat_answer       pending_answers [$];
    logic [IDX_W-1:0]  chain_heads [$];
    int                err_cnt = 0;
    int                cyc_cnt = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;

    fat_chain_table_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_cluster      (i_cluster),
        .i_value        (i_value),
        .i_prev_cluster (i_prev_cluster),
        .i_steps        (i_steps),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (o_result),
        .o_ok           (o_ok),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("FAIL fat_chain_table_engine");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------- table mirror ----------------

    function automatic logic [DATA_W-1:0] rd_entry(input logic [DATA_W-1:0] idx);
        return (idx < TBL_DEPTH) ? fat_mirror[idx[IDX_W-1:0]] : '0;
    endfunction

    function automatic void wr_entry(input logic [DATA_W-1:0] idx,
                                     input logic [DATA_W-1:0] val);
        if (idx < TBL_DEPTH)
            fat_mirror[idx[IDX_W-1:0]] = val;
    endfunction

    // First-fit scan from index 1; links tail to the new cluster when tail != 0.
    function automatic logic [DATA_W-1:0] grab_free(input logic [DATA_W-1:0] tail);
        int hi;
        hi = last_lim;
        if (hi > TBL_DEPTH - 1)
            hi = TBL_DEPTH - 1;
        for (int k = 1; k <= hi; k++) begin
            if (fat_mirror[k] == '0) begin
                if (tail != '0)
                    wr_entry(tail, DATA_W'(k));
                fat_mirror[k] = END_MARK;
                return DATA_W'(k);
            end
        end
        return '0;
    endfunction

    function automatic void apply_request(input logic [ACT_W-1:0] act,
                                          input logic [IDX_W-1:0] clu,
                                          input logic [DATA_W-1:0] val,
                                          input logic [IDX_W-1:0] prv,
                                          input logic [STEPS_W-1:0] stp,
                                          output logic [DATA_W-1:0] res,
                                          output logic ok);
        logic [DATA_W-1:0] cur;
        logic [DATA_W-1:0] nxt;
        res = '0;
        ok  = 1'b0;
        case (act)
            ACT_GET: begin
                res = fat_mirror[clu];
                ok  = 1'b1;
            end
            ACT_PUT: begin
                fat_mirror[clu] = val;
                ok = 1'b1;
            end
            ACT_GROW: begin
                res = grab_free(DATA_W'(clu));
                ok  = (res != '0);
            end
            ACT_FREE: begin
                cur = DATA_W'(clu);
                for (int n = 0; n < TBL_DEPTH; n++) begin
                    if (cur == END_MARK || cur == '0 || cur >= TBL_DEPTH)
                        break;
                    nxt = fat_mirror[cur[IDX_W-1:0]];
                    fat_mirror[cur[IDX_W-1:0]] = '0;
                    cur = nxt;
                end
                if (prv != '0 && rd_entry(DATA_W'(prv)) == DATA_W'(clu))
                    wr_entry(DATA_W'(prv), END_MARK);
                ok = 1'b1;
            end
            ACT_WALK: begin
                cur = DATA_W'(clu);
                ok  = 1'b1;
                for (int n = 0; n < stp; n++) begin
                    cur = rd_entry(cur);
                    if (cur == END_MARK || cur == '0) begin
                        ok = 1'b0;
                        break;
                    end
                end
                if (ok)
                    res = cur + DATA_W'(sect_base);
            end
            ACT_WALKX: begin
                cur = DATA_W'(clu);
                ok  = 1'b1;
                for (int n = 0; n < stp; n++) begin
                    nxt = rd_entry(cur);
                    if (nxt == '0) begin
                        ok = 1'b0;
                        break;
                    end
                    if (nxt == END_MARK) begin
                        nxt = grab_free(cur);
                        if (nxt == '0) begin
                            ok = 1'b0;
                            break;
                        end
                    end
                    cur = nxt;
                end
                if (ok)
                    res = cur + DATA_W'(sect_base);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] find_pred(input logic [IDX_W-1:0] clu);
        for (int k = 1; k < TBL_DEPTH; k++)
            if (fat_mirror[k] == DATA_W'(clu))
                return IDX_W'(k);
        return '0;
    endfunction

    // ---------------- checking ----------------

    task automatic note_mismatch(input string what);
        $display("mismatch @%0d: %s", cyc_cnt, what);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_fat_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                note_mismatch($sformatf("unexpected word result=%h ok=%b", o_result, o_ok));
            end else begin
                want = pending_answers.pop_front();
                if (o_result !== want.result)
                    note_mismatch($sformatf("result %h, want %h", o_result, want.result));
                if (o_ok !== want.ok)
                    note_mismatch($sformatf("ok %b, want %b", o_ok, want.ok));
            end
        end
    end

    // ---------------- driving ----------------

    task automatic send_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] clu,
                            input logic [DATA_W-1:0] val, input logic [IDX_W-1:0] prv,
                            input logic [STEPS_W-1:0] stp);
        t_fat_answer ans;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_cluster      <= clu;
        i_value        <= val;
        i_prev_cluster <= prv;
        i_steps        <= stp;
        do @(posedge i_clk); while (!o_in_ready);
        apply_request(act, clu, val, prv, stp, ans.result, ans.ok);
        pending_answers.push_back(ans);
        if (act == ACT_GROW && ans.ok) begin
            chain_heads.push_back(ans.result[IDX_W-1:0]);
            if (chain_heads.size() > MAX_HEADS)
                void'(chain_heads.pop_front());
        end
    endtask

    // Stop sending and let every outstanding word come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [LAST_W-1:0] lim, input logic [DS_W-1:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LAST;
        i_cfg_data  <= {4'($urandom), lim};
        @(posedge i_clk);
        last_lim = lim;
        i_cfg_index <= CFG_DSTART;
        i_cfg_data  <= base;
        @(posedge i_clk);
        sect_base = base;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_req();
        logic [ACT_W-1:0]   act;
        logic [IDX_W-1:0]   clu;
        logic [DATA_W-1:0]  val;
        logic [IDX_W-1:0]   prv;
        logic [STEPS_W-1:0] stp;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 10)      act = ACT_GET;
        else if (pick < 20) act = ACT_PUT;
        else if (pick < 45) act = ACT_GROW;
        else if (pick < 58) act = ACT_FREE;
        else if (pick < 76) act = ACT_WALK;
        else if (pick < 95) act = ACT_WALKX;
        else                act = $urandom_range(1) ? ACT_BAD_HI : ACT_BAD_LO;

        pick = $urandom_range(99);
        if (pick < 60 && chain_heads.size() != 0)
            clu = chain_heads[$urandom_range(chain_heads.size() - 1)];
        else if (pick < 85)
            clu = IDX_W'($urandom_range(last_lim));
        else
            clu = IDX_W'($urandom);
        if (act == ACT_GROW && $urandom_range(3) == 0)
            clu = '0;

        pick = $urandom_range(99);
        if (pick < 25)      val = '0;
        else if (pick < 40) val = END_MARK;
        else if (pick < 75) val = $urandom_range(last_lim);
        else                val = $urandom;

        pick = $urandom_range(99);
        if (pick < 50)      prv = '0;
        else if (pick < 80) prv = find_pred(clu);
        else                prv = IDX_W'($urandom);

        // long walks that keep extending only while the table is small
        pick = $urandom_range(99);
        if (pick < 70)
            stp = STEPS_W'($urandom_range(6));
        else if (pick < 90 || (act == ACT_WALKX && last_lim > 64))
            stp = STEPS_W'($urandom_range(40));
        else
            stp = STEPS_W'($urandom);

        send_req(act, clu, val, prv, stp);
    endtask

    // ---------------- tests ----------------

    task automatic test_table_access();
        send_req(ACT_GET, '0, '0, '0, '0);
        send_req(ACT_GET, IDX_MAX, '0, '0, '0);
        send_req(ACT_PUT, IDX_MAX, '1, '1, '1);
        send_req(ACT_GET, IDX_MAX, '0, '0, '0);
        send_req(ACT_PUT, '0, END_MARK, '0, '0);
    endtask

    task automatic test_chain_build();
        send_req(ACT_GROW, '0, '0, '0, '0);
        send_req(ACT_GROW, 12'd1, '0, '0, '0);
        send_req(ACT_WALK, 12'd1, '0, '0, 12'd1);
        send_req(ACT_WALK, '0, '0, '0, '0);
        send_req(ACT_WALK, 12'd1, '0, '0, '1);
        send_req(ACT_WALKX, 12'd1, '0, '0, 12'd3);
        // entry 0 holds the end mark: extending from cluster 0 starts a fresh chain
        send_req(ACT_WALKX, '0, '0, '0, 12'd1);
        send_req(ACT_WALK, IDX_MAX, '0, '0, 12'd1);
        send_req(ACT_WALK, IDX_MAX, '0, '0, 12'd2);
        // tail is the first free cluster itself
        send_req(ACT_GROW, 12'd6, '0, '0, '0);
    endtask

    task automatic test_chain_free();
        send_req(ACT_FREE, 12'd1, '0, '0, '0);
        send_req(ACT_FREE, '0, '0, 12'd9, '0);
        send_req(ACT_GROW, '0, '0, '0, '0);
        send_req(ACT_GROW, 12'd1, '0, '0, '0);
        send_req(ACT_FREE, 12'd2, '0, 12'd1, '0);
    endtask

    task automatic test_unknown_action();
        send_req(ACT_BAD_HI, '1, '1, '1, '1);
        send_req(ACT_BAD_LO, '0, '0, '0, '0);
        send_req(ACT_GET, IDX_MAX, '0, '0, '0);
    endtask

    task automatic test_exhaustion();
        wait_idle();
        set_config(12'd3, 16'hFFFF);
        send_req(ACT_GROW, '0, '0, '0, '0);
        send_req(ACT_GROW, 12'd2, '0, '0, '0);
        send_req(ACT_GROW, '0, '0, '0, '0);
        send_req(ACT_WALKX, 12'd2, '0, '0, '1);
        send_req(ACT_WALK, IDX_MAX, '0, '0, 12'd1);
        send_req(ACT_FREE, 12'd2, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items, input logic [LAST_W-1:0] lim,
                                       input logic [DS_W-1:0] base,
                                       input int idle, input int stall);
        wait_idle();
        set_config(lim, base);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int n = 0; n < n_items; n++) begin
            send_random_req();
            if ($urandom_range(59) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        foreach (fat_mirror[k])
            fat_mirror[k] = '0;
        last_lim  = LAST_RST;
        sect_base = DS_RST;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_out_ready    <= 1'b0;
        i_action       <= ACT_GET;
        i_cluster      <= '0;
        i_value        <= '0;
        i_prev_cluster <= '0;
        i_steps        <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_LAST;
        i_cfg_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_access();
        test_chain_build();
        test_chain_free();
        test_unknown_action();
        test_exhaustion();
        test_random_traffic(250, 12'd4095, 16'hFFFF, 0, 0);
        test_random_traffic(100, 12'd1, 16'h0000, 63, 0);
        test_random_traffic(150, 12'd200, 16'h8001, 63, 0);
        test_random_traffic(230, 12'd45, 16'd12345, 0, 63);
        test_random_traffic(220, 12'd4095, 16'h0000, 14, 14);

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS fat_chain_table_engine");
        else
            $display("FAIL fat_chain_table_engine");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_alu.sv
rtl/fct_table.sv
rtl/fct_ctrl.sv
rtl/fat_chain_table_engine.sv
bench/fat_chain_table_engine_test.sv
